>>> sv/csvt_pkg.sv
package csvt_pkg;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [2:0] {
		ST_REC_START   = 3'd0,
		ST_FIELD_START = 3'd1,
		ST_UNQUOTED    = 3'd2,
		ST_QUOTED      = 3'd3,
		ST_QUOTE_SEEN  = 3'd4,
		ST_AFTER_CR    = 3'd5,
		ST_ERROR       = 3'd6
	} parse_state_t;

	typedef enum logic [1:0] {
		TK_DATA   = 2'd0,
		TK_FIELD  = 2'd1,
		TK_RECORD = 2'd2,
		TK_ERROR  = 2'd3
	} token_kind_t;

	typedef struct packed {
		token_kind_t kind;
		logic [7:0]  data;
	} token_t;

	typedef struct packed {
		parse_state_t nxt;
		token_t       tok;
	} step_t;

endpackage

>>> sv/csvt_byte_if.sv
interface csvt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source(output valid, output data_byte, output end_of_input, input ready);
	modport sink(input valid, input data_byte, input end_of_input, output ready);
endinterface

>>> sv/csvt_token_if.sv
interface csvt_token_if import csvt_pkg::*; ;
	logic        valid;
	logic        ready;
	token_kind_t token_kind;
	logic [7:0]  token_byte;

	modport source(output valid, output token_kind, output token_byte, input ready);
	modport sink(input valid, input token_kind, input token_byte, output ready);
endinterface

>>> sv/csvt_step.sv
module csvt_step import csvt_pkg::*; (
	input  parse_state_t state,
	input  logic [7:0]   data_byte,
	input  logic         end_of_input,
	output parse_state_t next_state,
	output logic         tok_valid,
	output token_t       tok
);

	// byte outside quoted mode: terminators or plain data
	function automatic step_t plain(input logic [7:0] b);
		step_t r;
		r.tok.data = '0;
		priority if (b == CH_COMMA) begin
			r.nxt      = ST_FIELD_START;
			r.tok.kind = TK_FIELD;
		end else if (b == CH_CR) begin
			r.nxt      = ST_AFTER_CR;
			r.tok.kind = TK_RECORD;
		end else if (b == CH_LF) begin
			r.nxt      = ST_REC_START;
			r.tok.kind = TK_RECORD;
		end else begin
			r.nxt      = ST_UNQUOTED;
			r.tok.kind = TK_DATA;
			r.tok.data = b;
		end
		return r;
	endfunction

	step_t plain_r;
	logic  is_quote;
	logic  is_term;

	assign plain_r  = plain(data_byte);
	assign is_quote = (data_byte == CH_QUOTE);
	assign is_term  = (data_byte == CH_COMMA) || (data_byte == CH_CR) || (data_byte == CH_LF);

	always_comb begin
		next_state = state;
		tok_valid  = 1'b0;
		tok.kind   = TK_DATA;
		tok.data   = '0;
		if (end_of_input) begin
			next_state = ST_REC_START;
			unique case (state)
				ST_FIELD_START, ST_UNQUOTED, ST_QUOTE_SEEN: begin
					tok_valid = 1'b1;
					tok.kind  = TK_RECORD;
				end
				ST_QUOTED: begin
					tok_valid = 1'b1;
					tok.kind  = TK_ERROR;
				end
				default: ;
			endcase
		end else begin
			unique case (state)
				ST_ERROR: ;
				ST_QUOTED: begin
					if (is_quote) begin
						next_state = ST_QUOTE_SEEN;
					end else begin
						tok_valid = 1'b1;
						tok.data  = data_byte;
					end
				end
				ST_QUOTE_SEEN: begin
					tok_valid = 1'b1;
					priority if (is_quote) begin
						// doubled quote is a literal quote
						next_state = ST_QUOTED;
						tok.data   = CH_QUOTE;
					end else if (is_term) begin
						next_state = plain_r.nxt;
						tok        = plain_r.tok;
					end else begin
						next_state = ST_ERROR;
						tok.kind   = TK_ERROR;
					end
				end
				ST_UNQUOTED: begin
					tok_valid  = 1'b1;
					next_state = plain_r.nxt;
					tok        = plain_r.tok;
				end
				default: begin
					// record start, field start, after cr, unused code
					priority if (state == ST_AFTER_CR && data_byte == CH_LF) begin
						next_state = ST_REC_START;
					end else if (is_quote) begin
						next_state = ST_QUOTED;
					end else begin
						tok_valid  = 1'b1;
						next_state = plain_r.nxt;
						tok        = plain_r.tok;
					end
				end
			endcase
		end
	end

endmodule

>>> sv/csvt_outbuf.sv
module csvt_outbuf import csvt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  token_t              push_tok,
	output logic                can_accept,
	csvt_token_if.source        tokens
);

	logic   out_valid_q;
	token_t out_q;
	logic   skid_valid_q;
	token_t skid_q;
	logic   out_fire;

	assign out_fire   = out_valid_q && tokens.ready;
	assign can_accept = !skid_valid_q;

	assign tokens.valid      = out_valid_q;
	assign tokens.token_kind = out_q.kind;
	assign tokens.token_byte = out_q.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !out_fire) begin
				skid_q <= push_tok;
			end else begin
				out_q <= push_tok;
			end
		end
	end

endmodule

>>> sv/csv_record_tokenizer.sv
// channel  | modport | payload                         | transaction
// bytes    | sink    | data_byte[7:0], end_of_input    | one text byte or end mark
// tokens   | source  | token_kind[1:0], token_byte[7:0] | one token
//
// one byte per cycle while tokens are not stalled; a taken byte waits in the input register,
// then the parse step writes its token into the output register
// the output register plus a skid entry keep bytes flowing while a stalled token waits;
// once the skid entry is full, bytes.ready drops while a byte waits in the input register
// arst_n returns the parser to record start and empties all stages
module csv_record_tokenizer import csvt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	csvt_byte_if.sink    bytes,
	csvt_token_if.source tokens
);

	logic         valid_s1;
	logic [7:0]   data_byte_s1;
	logic         end_of_input_s1;
	parse_state_t state_q;
	parse_state_t next_state;
	logic         tok_valid;
	token_t       tok;
	logic         can_accept;
	logic         advance;

	assign advance     = valid_s1 && can_accept;
	assign bytes.ready = !valid_s1 || can_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= ST_REC_START;
		end else begin
			if (bytes.ready) begin
				valid_s1 <= bytes.valid;
			end
			if (advance) begin
				state_q <= next_state;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_byte_s1    <= bytes.data_byte;
			end_of_input_s1 <= bytes.end_of_input;
		end
	end

	csvt_step u_step (
		.state        (state_q),
		.data_byte    (data_byte_s1),
		.end_of_input (end_of_input_s1),
		.next_state   (next_state),
		.tok_valid    (tok_valid),
		.tok          (tok)
	);

	csvt_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (advance && tok_valid),
		.push_tok   (tok),
		.can_accept (can_accept),
		.tokens     (tokens)
	);

endmodule

>>> sv/csvt_checker.sv
module csvt_checker import csvt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] token_kind,
	input logic [7:0] token_byte
);

	// only data tokens carry a byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != TK_DATA |-> token_byte == 8'h00)
		else $error("non-data token with nonzero byte");

	// a fresh token follows an earlier byte transaction
	a_token_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("token without a preceding byte transaction");

	// with the output empty nothing can block the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output empty");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("token dropped under stall");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(token_kind) && $stable(token_byte))
		else $error("token changed under stall");

endmodule

bind csv_record_tokenizer csvt_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (bytes.valid),
	.in_ready   (bytes.ready),
	.out_valid  (tokens.valid),
	.out_ready  (tokens.ready),
	.token_kind (tokens.token_kind),
	.token_byte (tokens.token_byte)
);

>>> sim/csv_record_tokenizer_checker.sv
module csv_record_tokenizer_checker import csvt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	csvt_byte_if  bytes,
	csvt_token_if tokens,
	output int    failures,
	output int    pending
);

	parse_state_t parser_state;
	token_t       expected_tokens[$];
	int           token_count;

	function automatic token_t make_token(input token_kind_t kind, input logic [7:0] b);
		token_t t;
		t.kind = kind;
		t.data = (kind == TK_DATA) ? b : 8'h00;
		return t;
	endfunction

	// separator, terminator or plain data outside quotes
	function automatic token_t field_byte(input logic [7:0] b);
		case (b)
			CH_COMMA: begin
				parser_state = ST_FIELD_START;
				return make_token(TK_FIELD, 8'h00);
			end
			CH_CR: begin
				parser_state = ST_AFTER_CR;
				return make_token(TK_RECORD, 8'h00);
			end
			CH_LF: begin
				parser_state = ST_REC_START;
				return make_token(TK_RECORD, 8'h00);
			end
			default: begin
				parser_state = ST_UNQUOTED;
				return make_token(TK_DATA, b);
			end
		endcase
	endfunction

	// advances the parser by one byte; returns 1 when a token comes out
	function automatic bit tokenize_byte(input logic [7:0] b, input logic eoi,
			output token_t tok);
		parse_state_t st;
		st = parser_state;
		tok = '0;
		if (eoi) begin
			parser_state = ST_REC_START;
			case (st)
				ST_FIELD_START, ST_UNQUOTED, ST_QUOTE_SEEN: begin
					tok = make_token(TK_RECORD, 8'h00);
					return 1'b1;
				end
				ST_QUOTED: begin
					tok = make_token(TK_ERROR, 8'h00);
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		end
		case (st)
			ST_ERROR: return 1'b0;
			ST_QUOTED: begin
				if (b == CH_QUOTE) begin
					parser_state = ST_QUOTE_SEEN;
					return 1'b0;
				end
				tok = make_token(TK_DATA, b);
				return 1'b1;
			end
			ST_QUOTE_SEEN: begin
				if (b == CH_QUOTE) begin
					parser_state = ST_QUOTED;
					tok = make_token(TK_DATA, CH_QUOTE);
					return 1'b1;
				end
				if (b == CH_COMMA || b == CH_CR || b == CH_LF) begin
					tok = field_byte(b);
					return 1'b1;
				end
				parser_state = ST_ERROR;
				tok = make_token(TK_ERROR, 8'h00);
				return 1'b1;
			end
			ST_UNQUOTED: begin
				tok = field_byte(b);
				return 1'b1;
			end
			ST_AFTER_CR: begin
				if (b == CH_LF) begin
					parser_state = ST_REC_START;
					return 1'b0;
				end
				if (b == CH_QUOTE) begin
					parser_state = ST_QUOTED;
					return 1'b0;
				end
				tok = field_byte(b);
				return 1'b1;
			end
			default: begin
				if (b == CH_QUOTE) begin
					parser_state = ST_QUOTED;
					return 1'b0;
				end
				tok = field_byte(b);
				return 1'b1;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t token %0d: %s", $time, token_count, msg);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_t tok;
		token_t want;
		if (!arst_n) begin
			parser_state = ST_REC_START;
			expected_tokens.delete();
			pending = 0;
			failures = 0;
			token_count = 0;
		end else begin
			// a token never fires at the edge that takes its byte, so check before predicting
			if (tokens.valid && tokens.ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch($sformatf("unexpected token kind %0d byte %h",
						tokens.token_kind, tokens.token_byte));
				end else begin
					want = expected_tokens.pop_front();
					if (tokens.token_kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %0d",
							tokens.token_kind, want.kind));
					if (tokens.token_byte !== want.data)
						report_mismatch($sformatf("byte %h, expected %h",
							tokens.token_byte, want.data));
				end
				token_count++;
			end
			if (bytes.valid && bytes.ready) begin
				if (tokenize_byte(bytes.data_byte, bytes.end_of_input, tok))
					expected_tokens.insert(expected_tokens.size(), tok);
			end
			pending = expected_tokens.size();
		end
	end

endmodule

>>> sim/csv_record_tokenizer_tb.sv
module csv_record_tokenizer_tb import csvt_pkg::*; ;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   failures;
	int   pending;
	int   items_sent = 0;
	int   ready_hold = 0;
	bit   calm = 1'b0;

	csvt_byte_if  byte_ch();
	csvt_token_if token_ch();

	csv_record_tokenizer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.tokens (token_ch)
	);

	csv_record_tokenizer_checker token_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (byte_ch),
		.tokens   (token_ch),
		.failures (failures),
		.pending  (pending)
	);

	always #2 clk = ~clk;

	// mostly no gap, sometimes short, rarely long; none during calm stretches
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		int stall;
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (token_ch.ready) begin
			stall = pick_gap();
			if (stall > 0) begin
				token_ch.ready <= 1'b0;
				ready_hold = stall - 1;
			end else begin
				ready_hold = $urandom_range(0, 7);
			end
		end else begin
			token_ch.ready <= 1'b1;
			ready_hold = $urandom_range(0, 10);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eoi);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.end_of_input <= eoi;
		do @(posedge clk); while (!byte_ch.ready);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_byte(s[i], 1'b0);
	endtask

	task automatic send_end();
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 3) == 0)
				b = 8'($urandom_range(0, 255));
			else
				b = 8'($urandom_range(8'h61, 8'h7a));
		end while (b inside {CH_COMMA, CH_QUOTE, CH_CR, CH_LF});
		return b;
	endfunction

	function automatic logic [7:0] special_byte();
		case ($urandom_range(0, 3))
			0: return CH_COMMA;
			1: return CH_QUOTE;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	task automatic send_unquoted();
		int len;
		len = $urandom_range(0, 6);
		for (int i = 0; i < len; i++) begin
			// a quote past the first byte is plain data
			if (i > 0 && $urandom_range(0, 9) == 0)
				send_byte(CH_QUOTE, 1'b0);
			else
				send_byte(text_byte(), 1'b0);
		end
	endtask

	task automatic send_quoted();
		int len;
		logic [7:0] b;
		len = $urandom_range(0, 6);
		send_byte(CH_QUOTE, 1'b0);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0, 1: b = special_byte();
				2, 3: b = 8'($urandom_range(0, 255));
				default: b = text_byte();
			endcase
			send_byte(b, 1'b0);
			if (b == CH_QUOTE)
				send_byte(CH_QUOTE, 1'b0);
		end
		send_byte(CH_QUOTE, 1'b0);
	endtask

	task automatic send_record();
		int fields;
		fields = $urandom_range(1, 4);
		for (int f = 0; f < fields; f++) begin
			if (f > 0)
				send_byte(CH_COMMA, 1'b0);
			if ($urandom_range(0, 1))
				send_quoted();
			else
				send_unquoted();
		end
		case ($urandom_range(0, 5))
			0, 1: begin
				send_byte(CH_CR, 1'b0);
				send_byte(CH_LF, 1'b0);
			end
			2, 3: send_byte(CH_LF, 1'b0);
			4: send_byte(CH_CR, 1'b0);
			default: send_end();
		endcase
	endtask

	// unstructured bytes heavy in separators and quotes, often leading to errors
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 2))
				0: send_byte(special_byte(), 1'b0);
				1: send_byte(8'($urandom_range(0, 255)), 1'b0);
				default: send_byte(text_byte(), 1'b0);
			endcase
		end
		if ($urandom_range(0, 9) < 6)
			send_end();
	endtask

	initial begin
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.end_of_input = 1'b0;
		token_ch.ready = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("a,");
		send_byte(8'hFF, 1'b0);
		// crlf is one terminator
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_LF, 1'b0);
		// quoted null byte, doubled quote, then comma after closing quote
		send_byte(CH_QUOTE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("\"\"\",");
		send_byte(CH_CR, 1'b0);
		// quote right after cr opens a quoted field, garbage after it closes
		send_text("\"\"z");
		send_text("x,");
		send_byte(8'hFF, 1'b1);
		send_text("q\"");
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b1);
		send_text("\"a");
		send_end();
		send_text("\"\"");
		send_end();
		send_text(",");
		send_end();
		// cr at record start followed by a plain byte
		send_byte(CH_CR, 1'b0);
		send_text("b");
		send_end();

		while (items_sent < 1150) begin
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 99) < 85)
				send_record();
			else
				send_noise();
		end
		calm = 1'b0;
		send_end();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> csv_record_tokenizer.f
sv/csvt_pkg.sv
sv/csvt_byte_if.sv
sv/csvt_token_if.sv
sv/csvt_step.sv
sv/csvt_outbuf.sv
sv/csv_record_tokenizer.sv
sv/csvt_checker.sv
sim/csv_record_tokenizer_checker.sv
sim/csv_record_tokenizer_tb.sv
